// ===== rtl/wre_pkg.sv =====
package wre_pkg;

  localparam int ROW_COUNT_BITS    = 31;
  localparam int PERCENT_FRAC_BITS = 32;
  localparam int PCT_BITS          = PERCENT_FRAC_BITS + 1;

  localparam logic [ROW_COUNT_BITS-1:0] ROW_MAX = {ROW_COUNT_BITS{1'b1}};
  localparam logic [ROW_COUNT_BITS-1:0] ROW_ONE = ROW_COUNT_BITS'(1);
  localparam logic [PCT_BITS-1:0]       PCT_ONE = {1'b1, {PERCENT_FRAC_BITS{1'b0}}};

  typedef logic [1:0] rank_mode_t;

  localparam rank_mode_t MODE_RANK    = 2'd0;
  localparam rank_mode_t MODE_DENSE   = 2'd1;
  localparam rank_mode_t MODE_PERCENT = 2'd2;

  typedef struct packed {
    logic                      first_in_partition;
    logic [ROW_COUNT_BITS-1:0] partition_rows;
    logic [ROW_COUNT_BITS-1:0] peer_group_start;
  } in_item_t;

  typedef struct packed {
    logic [ROW_COUNT_BITS-1:0] rank_value;
    logic [PCT_BITS-1:0]       percent_value;
  } out_item_t;

  // One ranked row waiting for the back end.
  typedef struct packed {
    logic [ROW_COUNT_BITS-1:0] rank;
    logic [ROW_COUNT_BITS-1:0] rows;
    rank_mode_t                mode;
  } rank_job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } back_state_t;

endpackage

// ===== rtl/wre_front.sv =====
module wre_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  wre_pkg::in_item_t  in_data,
  input  wre_pkg::rank_mode_t mode,
  input  logic               job_full,
  output logic               job_push,
  output wre_pkg::rank_job_t job
);
  import wre_pkg::*;

  logic [ROW_COUNT_BITS-1:0] group_start_r, group_start_nxt;
  logic [ROW_COUNT_BITS-1:0] peer_count_r, peer_count_nxt;
  logic [ROW_COUNT_BITS-1:0] rank_r, rank_nxt;
  logic [ROW_COUNT_BITS-1:0] rows_r, rows_nxt;

  logic [ROW_COUNT_BITS-1:0] rank_base, start_base, peer_base, rank_inc;
  logic [ROW_COUNT_BITS:0]   rank_sum, peer_sum;
  logic                      new_group;

  assign job_push = push && !job_full;

  always_comb begin
    // a new partition restarts the recurrence before this row is ranked
    rank_base  = in_data.first_in_partition ? ROW_ONE : rank_r;
    start_base = in_data.first_in_partition ? '0 : group_start_r;
    peer_base  = in_data.first_in_partition ? '0 : peer_count_r;
    rows_nxt   = in_data.first_in_partition ? in_data.partition_rows : rows_r;

    new_group = (in_data.peer_group_start != start_base);

    if (mode == MODE_DENSE) begin
      rank_inc = (peer_base != '0) ? ROW_ONE : '0;
    end else begin
      rank_inc = peer_base;
    end

    rank_sum = {1'b0, rank_base} + {1'b0, rank_inc};
    peer_sum = {1'b0, peer_base} + {1'b0, ROW_ONE};

    if (new_group) begin
      rank_nxt        = rank_sum[ROW_COUNT_BITS] ? ROW_MAX : rank_sum[ROW_COUNT_BITS-1:0];
      group_start_nxt = in_data.peer_group_start;
      peer_count_nxt  = ROW_ONE;
    end else begin
      rank_nxt        = rank_base;
      group_start_nxt = start_base;
      peer_count_nxt  = peer_sum[ROW_COUNT_BITS] ? ROW_MAX : peer_sum[ROW_COUNT_BITS-1:0];
    end

    job.rank = rank_nxt;
    job.rows = rows_nxt;
    job.mode = mode;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_start_r <= '0;
      peer_count_r  <= '0;
      rank_r        <= ROW_ONE;
      rows_r        <= ROW_ONE;
    end else if (job_push) begin
      group_start_r <= group_start_nxt;
      peer_count_r  <= peer_count_nxt;
      rank_r        <= rank_nxt;
      rows_r        <= rows_nxt;
    end
  end

endmodule

// ===== rtl/wre_fifo.sv =====
module wre_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  wre_pkg::rank_job_t wr_data,
  output logic               full,
  input  logic               rd_en,
  output wre_pkg::rank_job_t rd_data,
  output logic               empty
);
  import wre_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

  rank_job_t mem [DEPTH];

  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                do_wr, do_rd;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_BITS'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_BITS'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/wre_back.sv =====
module wre_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_empty,
  input  wre_pkg::rank_job_t job,
  output logic               job_pop,
  output logic               empty,
  input  logic               pop,
  output wre_pkg::out_item_t out_data
);
  import wre_pkg::*;

  localparam int STEP_BITS = $clog2(PERCENT_FRAC_BITS);
  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(PERCENT_FRAC_BITS - 1);

  back_state_t state_r, state_nxt;

  logic [ROW_COUNT_BITS-1:0] rank_r;
  logic [ROW_COUNT_BITS-1:0] rows_r;
  logic [ROW_COUNT_BITS-1:0] rem_r;
  logic [ROW_COUNT_BITS-1:0] den_r;
  logic [PCT_BITS-1:0]       quo_r;
  logic [STEP_BITS-1:0]      step_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  logic                      out_free, out_load, job_take;
  out_item_t                 out_load_data;
  logic [ROW_COUNT_BITS:0]   rem_sh;
  logic                      rem_ge;
  logic [ROW_COUNT_BITS:0]   rem_diff;

  assign out_free = !out_valid_r || pop;
  assign empty    = !out_valid_r;
  assign out_data = out_data_r;

  // one restoring step per cycle
  assign rem_sh   = {rem_r, 1'b0};
  assign rem_ge   = (rem_sh >= {1'b0, den_r});
  assign rem_diff = rem_sh - {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!job_empty && (job.mode == MODE_PERCENT)) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if ((rows_r > ROW_ONE) && (rank_r < rows_r)) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        if (step_r == STEP_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    job_pop       = 1'b0;
    job_take      = 1'b0;
    out_load      = 1'b0;
    out_load_data = '{rank_value: rank_r, percent_value: quo_r};
    case (state_r)
      ST_IDLE: begin
        if (!job_empty) begin
          if (job.mode == MODE_PERCENT) begin
            job_pop  = 1'b1;
            job_take = 1'b1;
          end else if (out_free) begin
            // plain and dense ranks go straight to the output register
            job_pop       = 1'b1;
            out_load      = 1'b1;
            out_load_data = '{rank_value: job.rank, percent_value: '0};
          end
        end
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      rank_r <= job.rank;
      rows_r <= job.rows;
    end
    case (state_r)
      ST_PREP: begin
        rem_r  <= rank_r - ROW_ONE;
        den_r  <= rows_r - ROW_ONE;
        step_r <= '0;
        if (rows_r <= ROW_ONE) begin
          quo_r <= '0;
        end else if (rank_r >= rows_r) begin
          quo_r <= PCT_ONE;
        end else begin
          quo_r <= '0;
        end
      end
      ST_DIV: begin
        rem_r  <= rem_ge ? rem_diff[ROW_COUNT_BITS-1:0] : rem_sh[ROW_COUNT_BITS-1:0];
        quo_r  <= {quo_r[PCT_BITS-2:0], rem_ge};
        step_r <= step_r + STEP_BITS'(1);
      end
      default: begin
        step_r <= step_r;
      end
    endcase
    if (out_load) begin
      out_data_r <= out_load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < den_r))
    else $error("divider remainder reached the divisor");

  a_pct_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.percent_value <= PCT_ONE))
    else $error("percent rank above 1.0");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> !job_empty)
    else $error("back end took a job from an empty queue");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !pop) |=> (out_valid_r && $stable(out_data_r)))
    else $error("waiting result was overwritten");

endmodule

// ===== rtl/window_rank_engine.sv =====
// SQL window ranking over a stream of rows already sorted within their
// partition. Each pushed beat carries a first-of-partition flag, the
// partition's row count and the row index where the row's peer group starts;
// each popped beat returns the rank (mode 0, or 3), the dense rank (mode 1),
// and in mode 2 also the percent rank (rank-1)/(rows-1) as an unsigned
// fraction with 32 fractional bits, truncated, where 2^32 means 1.0 and a
// partition of one row gives 0. Rank and peer counters saturate at 2^31-1.
// Rate: the front end ranks one row per cycle unless the small job queue is
// full. In modes 0, 1 and 3 the back end retires one row per cycle while
// results are popped. In mode 2 each row occupies the back end's restoring
// divider, one quotient bit per cycle, until its result is loaded; rows of a
// one-row partition or with rank at or above the row count skip the divider.
// rank_mode sits at byte address 0 of the APB port; change it only while no
// row is in flight.
module window_rank_engine #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  // row input
  input  logic               push,
  output logic               full,
  input  wre_pkg::in_item_t  in_data,
  // rank results
  output logic               empty,
  input  logic               pop,
  output wre_pkg::out_item_t out_data,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import wre_pkg::*;

  rank_mode_t mode_r;
  logic       cfg_wr;
  logic       job_push, job_full, job_pop, job_empty;
  rank_job_t  job_in, job_out;

  // Only one register, at byte address 0.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == 2'd0);
  assign prdata = {30'd0, mode_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RANK;
    end else if (cfg_wr) begin
      mode_r <= pwdata[1:0];
    end
  end

  // Rank each row as it arrives; the mode travels with the job.
  assign full = job_full;

  wre_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .mode     (mode_r),
    .job_full (job_full),
    .job_push (job_push),
    .job      (job_in)
  );

  // Decouple ranking from the divider.
  wre_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_data (job_in),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_data (job_out),
    .empty   (job_empty)
  );

  // Compute percent rank and hold the result beat until popped.
  wre_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule
